@@ design/bhrd_pkg.sv @@
// Package for the button hold/release detector.
// Holds the payload structs, opcode and register index codes, and reset values.
// No dependencies.
package bhrd_pkg;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_ARM    = 1'b1
    } opcode_t;

    localparam int CFG_INDEX_WIDTH = 4;
    localparam int CFG_DATA_WIDTH  = 32;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DEBOUNCE_TIME = CFG_INDEX_WIDTH'(0);
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_HOLD_TIME     = CFG_INDEX_WIDTH'(1);

    localparam logic [15:0] DEBOUNCE_RESET = 16'd50;
    localparam logic [31:0] HOLD_RESET     = 32'd5000;

    typedef struct packed {
        opcode_t     opcode;
        logic        pin_level;
        logic [15:0] delta_ms;
    } in_item_t;

    typedef struct packed {
        logic        qualified_release;
        logic        release_seen;
        logic        hold_met;
        logic        latched;
        logic [31:0] press_time_ms;
    } out_item_t;

endpackage

@@ design/bhrd_core.sv @@
// Detector state and its per-item update.
// Depends on bhrd_pkg for the item structs and opcodes.
// The result is combinational from the current state and the item; state updates on accept.
module bhrd_core #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  bhrd_pkg::in_item_t  item,
    input  logic [15:0]         debounce_time,
    input  logic [31:0]         hold_time,
    output bhrd_pkg::out_item_t result
);

    localparam int CMP_WIDTH = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;

    logic                  raw_level_reg,       raw_level_next;
    logic                  stable_level_reg,    stable_level_next;
    logic                  stable_valid_reg,    stable_valid_next;
    logic [TIME_WIDTH-1:0] raw_time_reg,        raw_time_next;
    logic [TIME_WIDTH-1:0] press_time_reg,      press_time_next;
    logic                  release_seen_reg,    release_seen_next;
    logic                  hold_met_reg,        hold_met_next;
    logic                  latched_reg,         latched_next;
    logic                  fired;
    logic                  changed;
    logic [TIME_WIDTH-1:0] elapsed_ext;

    function automatic logic [TIME_WIDTH-1:0] sat_add(input logic [TIME_WIDTH-1:0] a,
                                                      input logic [TIME_WIDTH-1:0] b);
        logic [TIME_WIDTH:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[TIME_WIDTH] ? {TIME_WIDTH{1'b1}} : sum[TIME_WIDTH-1:0];
    endfunction

    assign elapsed_ext = TIME_WIDTH'(item.delta_ms);

    always_comb begin
        raw_level_next    = raw_level_reg;
        stable_level_next = stable_level_reg;
        stable_valid_next = stable_valid_reg;
        raw_time_next     = raw_time_reg;
        press_time_next   = press_time_reg;
        release_seen_next = release_seen_reg;
        hold_met_next     = hold_met_reg;
        latched_next      = latched_reg;
        fired             = 1'b0;
        changed           = !stable_valid_reg || (stable_level_reg != item.pin_level);

        if (item.opcode == bhrd_pkg::OP_ARM) begin
            raw_level_next    = item.pin_level;
            stable_level_next = item.pin_level;
            stable_valid_next = 1'b0;
            raw_time_next     = '0;
            press_time_next   = '0;
            release_seen_next = 1'b0;
            hold_met_next     = 1'b0;
            latched_next      = 1'b0;
        end else if (item.delta_ms != 16'd0 && !latched_reg) begin
            raw_level_next = item.pin_level;
            if (item.pin_level != raw_level_reg) begin
                raw_time_next = elapsed_ext;
            end else begin
                raw_time_next = sat_add(raw_time_reg, elapsed_ext);
            end

            if (raw_time_next >= TIME_WIDTH'(debounce_time)) begin
                stable_level_next = item.pin_level;
                stable_valid_next = 1'b1;
                if (item.pin_level) begin
                    release_seen_next = 1'b1;
                    press_time_next   = '0;
                    // debounced edge from low to high after a long enough press
                    if (changed && !stable_level_reg && hold_met_reg) begin
                        latched_next = 1'b1;
                        fired        = 1'b1;
                    end else begin
                        hold_met_next = 1'b0;
                    end
                end else if (!release_seen_reg) begin
                    press_time_next = '0;
                    hold_met_next   = 1'b0;
                end else begin
                    press_time_next = changed ? elapsed_ext
                                              : sat_add(press_time_reg, elapsed_ext);
                    if (CMP_WIDTH'(press_time_next) >= CMP_WIDTH'(hold_time)) begin
                        hold_met_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_level_reg    <= 1'b1;
            stable_level_reg <= 1'b1;
            stable_valid_reg <= 1'b0;
            raw_time_reg     <= '0;
            press_time_reg   <= '0;
            release_seen_reg <= 1'b0;
            hold_met_reg     <= 1'b0;
            latched_reg      <= 1'b0;
        end else if (accept) begin
            raw_level_reg    <= raw_level_next;
            stable_level_reg <= stable_level_next;
            stable_valid_reg <= stable_valid_next;
            raw_time_reg     <= raw_time_next;
            press_time_reg   <= press_time_next;
            release_seen_reg <= release_seen_next;
            hold_met_reg     <= hold_met_next;
            latched_reg      <= latched_next;
        end
    end

    assign result.qualified_release = fired;
    assign result.release_seen      = release_seen_next;
    assign result.hold_met          = hold_met_next;
    assign result.latched           = latched_next;

    generate
        if (TIME_WIDTH > 32) begin : g_sat_out
            assign result.press_time_ms = (|press_time_next[TIME_WIDTH-1:32]) ? 32'hFFFF_FFFF
                                                                       : press_time_next[31:0];
        end else begin : g_ext_out
            assign result.press_time_ms = 32'(press_time_next);
        end
    endgenerate

endmodule

@@ design/button_hold_release_detector.sv @@
// Top level of the debounced long-press release detector.
// Depends on bhrd_pkg and bhrd_core; holds the config registers and the result buffer.
//
// Takes one sample or arm item per cycle while s_ready is high and returns exactly
// one registered result per item. The whole state update is a single pass of
// compares and saturating adds, so an item can be accepted every cycle while s_ready
// is high. The result side has an output register plus one skid entry: s_ready drops
// only when both are full, and it is a register, with no combinational path from
// m_ready. Config writes are always accepted (cfg_ready is tied high); writes to
// unknown indexes are dropped. Write config only while no items are in flight.
module button_hold_release_detector #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  bhrd_pkg::in_item_t                   s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output bhrd_pkg::out_item_t                  m_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bhrd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [bhrd_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

    logic [15:0]         debounce_reg;
    logic [31:0]         hold_reg;
    logic                out_valid_reg;
    logic                skid_valid_reg;
    bhrd_pkg::out_item_t out_data_reg;
    bhrd_pkg::out_item_t skid_data_reg;
    bhrd_pkg::out_item_t result;
    logic                s_accept;

    assign cfg_ready = 1'b1;
    assign s_ready   = !skid_valid_reg;
    assign s_accept  = s_valid && s_ready;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= bhrd_pkg::DEBOUNCE_RESET;
            hold_reg     <= bhrd_pkg::HOLD_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                bhrd_pkg::CFG_DEBOUNCE_TIME: debounce_reg <= cfg_data[15:0];
                bhrd_pkg::CFG_HOLD_TIME:     hold_reg     <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    bhrd_core #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (s_accept),
        .item          (s_data),
        .debounce_time (debounce_reg),
        .hold_time     (hold_reg),
        .result        (result)
    );

    // output register plus one skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_valid_reg && !m_ready) begin
            if (s_accept) begin
                skid_valid_reg <= 1'b1;
                skid_data_reg  <= result;
            end
        end else if (skid_valid_reg) begin
            out_valid_reg  <= 1'b1;
            out_data_reg   <= skid_data_reg;
            skid_valid_reg <= 1'b0;
        end else if (s_accept) begin
            out_valid_reg <= 1'b1;
            out_data_reg  <= result;
        end else begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule

@@ design/bhrd_checker.sv @@
// Port-level checks for button_hold_release_detector, bound onto the top level.
// Depends on bhrd_pkg for the result struct.
module bhrd_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input bhrd_pkg::out_item_t m_data
);

    // a release event always latches the detector and needs a prior release
    a_fire_latches: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.qualified_release |-> m_data.latched && m_data.release_seen)
        else $error("qualified release without latch or release_seen");

    // hold can only be met on a press counted after a release
    a_hold_needs_release: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.hold_met |-> m_data.release_seen)
        else $error("hold_met without release_seen");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

endmodule

bind button_hold_release_detector bhrd_checker u_bhrd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

@@ tb/tb_button_hold_release_detector.sv @@
// Self-checking testbench for button_hold_release_detector.
// Keeps its own model of the debounce and long-press logic and checks every result.
// Depends on bhrd_pkg and the design sources.
module tb_button_hold_release_detector;

    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int RANDOM_ITEMS  = 620;
    localparam int REPORT_LIMIT  = 10;
    localparam int CFG_LAST_INDEX = 2**bhrd_pkg::CFG_INDEX_WIDTH - 1;
    localparam logic [bhrd_pkg::CFG_INDEX_WIDTH-1:0] CFG_FIRST_UNUSED =
        bhrd_pkg::CFG_HOLD_TIME + 1'b1;
    localparam logic [31:0] TIME_SAT = 32'hFFFF_FFFF;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    bhrd_pkg::in_item_t  s_data    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    bhrd_pkg::out_item_t m_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [bhrd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [bhrd_pkg::CFG_DATA_WIDTH-1:0]  cfg_data  = '0;

    button_hold_release_detector dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 aclk = ~aclk;

    // Detector model state
    logic [15:0] debounce_ms = bhrd_pkg::DEBOUNCE_RESET;
    logic [31:0] hold_ms     = bhrd_pkg::HOLD_RESET;
    logic        raw_lvl     = 1'b1;
    logic        stable_lvl  = 1'b1;
    logic        stable_ok   = 1'b0;
    logic [31:0] raw_time    = '0;
    logic [31:0] press_time  = '0;
    logic        release_seen = 1'b0;
    logic        hold_met    = 1'b0;
    logic        latched     = 1'b0;

    bhrd_pkg::out_item_t expected_status[$];

    int unsigned items_sent;
    int unsigned results_checked;
    int unsigned releases_fired;
    int unsigned mismatch_count;
    int unsigned input_stalls;
    int unsigned cycle_count;

    int unsigned burst_left;
    bit          gaps_enabled = 1'b1;
    int unsigned hold_off_request;
    int unsigned elapsed_span = 64;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[32] ? TIME_SAT : sum[31:0];
    endfunction

    function automatic bhrd_pkg::out_item_t advance_detector(input bhrd_pkg::in_item_t item);
        bhrd_pkg::out_item_t res;
        logic                changed;
        logic                prior;
        res = '0;
        if (item.opcode == bhrd_pkg::OP_ARM) begin
            raw_lvl      = item.pin_level;
            stable_lvl   = item.pin_level;
            stable_ok    = 1'b0;
            raw_time     = '0;
            press_time   = '0;
            release_seen = 1'b0;
            hold_met     = 1'b0;
            latched      = 1'b0;
        end else if (item.delta_ms != 0 && !latched) begin
            if (item.pin_level != raw_lvl) begin
                raw_lvl  = item.pin_level;
                raw_time = {16'd0, item.delta_ms};
            end else begin
                raw_time = sat_add(raw_time, {16'd0, item.delta_ms});
            end
            if (raw_time >= {16'd0, debounce_ms}) begin
                changed    = !stable_ok || stable_lvl != raw_lvl;
                prior      = stable_lvl;
                stable_lvl = raw_lvl;
                stable_ok  = 1'b1;
                if (stable_lvl) begin
                    release_seen = 1'b1;
                    press_time   = '0;
                    if (changed && !prior && hold_met) begin
                        latched               = 1'b1;
                        res.qualified_release = 1'b1;
                    end else begin
                        hold_met = 1'b0;
                    end
                end else if (!release_seen) begin
                    press_time = '0;
                    hold_met   = 1'b0;
                end else begin
                    if (changed)
                        press_time = '0;
                    press_time = sat_add(press_time, {16'd0, item.delta_ms});
                    if (press_time >= hold_ms)
                        hold_met = 1'b1;
                end
            end
        end
        res.release_seen  = release_seen;
        res.hold_met      = hold_met;
        res.latched       = latched;
        res.press_time_ms = press_time;
        return res;
    endfunction

    // Called at a rising edge; returns at the edge where the transfer happens.
    task automatic send_item(input bhrd_pkg::opcode_t op, input logic level,
                             input logic [15:0] elapsed);
        bhrd_pkg::in_item_t item;
        int unsigned        gap;
        item.opcode    = op;
        item.pin_level = level;
        item.delta_ms  = elapsed;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = gaps_enabled ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        expected_status.push_back(advance_detector(item));
        items_sent++;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_status.size() != 0);
    endtask

    task automatic write_register(input logic [bhrd_pkg::CFG_INDEX_WIDTH-1:0] index,
                                  input logic [bhrd_pkg::CFG_DATA_WIDTH-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        if (index == bhrd_pkg::CFG_DEBOUNCE_TIME)
            debounce_ms = value[15:0];
        else if (index == bhrd_pkg::CFG_HOLD_TIME)
            hold_ms = value;
    endtask

    // Block idle first; an unmapped index gets junk to show it is dropped.
    task automatic set_timing(input logic [15:0] debounce, input logic [31:0] hold);
        drain_results();
        write_register(bhrd_pkg::CFG_INDEX_WIDTH'($urandom_range(CFG_FIRST_UNUSED,
                                                                 CFG_LAST_INDEX)),
                       $urandom);
        write_register(bhrd_pkg::CFG_DEBOUNCE_TIME, {16'($urandom), debounce});
        write_register(bhrd_pkg::CFG_HOLD_TIME, hold);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_elapsed();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 8)
            return 16'd0;
        else if (roll < 16)
            return 16'($urandom);
        else if (roll < 20)
            return 16'hFFFF;
        return 16'($urandom_range(1, elapsed_span));
    endfunction

    // Result check
    always @(posedge aclk) begin
        bhrd_pkg::out_item_t want;
        if (aresetn && s_valid && !s_ready)
            input_stalls++;
        if (aresetn && m_valid && m_ready) begin
            if (expected_status.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected result: rel=%0b seen=%0b hold=%0b latch=%0b press=%0d",
                             m_data.qualified_release, m_data.release_seen, m_data.hold_met,
                             m_data.latched, m_data.press_time_ms);
            end else begin
                want = expected_status.pop_front();
                results_checked++;
                if (want.qualified_release)
                    releases_fired++;
                if (m_data.qualified_release !== want.qualified_release ||
                    m_data.release_seen !== want.release_seen ||
                    m_data.hold_met !== want.hold_met ||
                    m_data.latched !== want.latched ||
                    m_data.press_time_ms !== want.press_time_ms) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display({"mismatch at result %0d: exp rel=%0b seen=%0b hold=%0b ",
                                  "latch=%0b press=%0d, got rel=%0b seen=%0b hold=%0b ",
                                  "latch=%0b press=%0d"},
                                 results_checked, want.qualified_release, want.release_seen,
                                 want.hold_met, want.latched, want.press_time_ms,
                                 m_data.qualified_release, m_data.release_seen,
                                 m_data.hold_met, m_data.latched, m_data.press_time_ms);
                end
            end
        end
    end

    // Result side: random stall patterns, plus requested hold-offs
    always @(posedge aclk) begin : receiver
        int unsigned stall_pct;
        int unsigned pattern_left;
        int unsigned hold_left;
        if (hold_off_request > 0) begin
            hold_left        = hold_off_request;
            hold_off_request = 0;
        end
        if (pattern_left == 0) begin
            pattern_left = $urandom_range(16, 80);
            case ($urandom_range(5))
                0, 1:    stall_pct = 0;
                2:       stall_pct = 15;
                3:       stall_pct = 35;
                4:       stall_pct = 55;
                default: stall_pct = 75;
            endcase
        end
        pattern_left--;
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_status.size());
            $display("tb_button_hold_release_detector NOT OK");
            $finish;
        end
    end

    // Reset values of both registers: bounce, debounced release, long press, release
    task automatic test_reset_timing();
        send_item(bhrd_pkg::OP_SAMPLE, 1'b1, 16'd0);
        send_item(bhrd_pkg::OP_SAMPLE, 1'b1, 16'd30);
        send_item(bhrd_pkg::OP_SAMPLE, 1'b1, 16'd30);
        send_item(bhrd_pkg::OP_SAMPLE, 1'b0, 16'hFFFF);
        send_item(bhrd_pkg::OP_SAMPLE, 1'b1, 16'd20);
        send_item(bhrd_pkg::OP_SAMPLE, 1'b1, 16'd40);
        send_item(bhrd_pkg::OP_SAMPLE, 1'b0, 16'd100);
        send_item(bhrd_pkg::OP_ARM, 1'b0, 16'hFFFF);
    endtask

    // Zero debounce and hold, press before any release, maximum debounce
    task automatic test_special_cases();
        set_timing(16'd0, 32'd0);
        send_item(bhrd_pkg::OP_ARM, 1'b0, 16'd0);
        send_item(bhrd_pkg::OP_SAMPLE, 1'b0, 16'd10);
        send_item(bhrd_pkg::OP_SAMPLE, 1'b1, 16'd0);
        send_item(bhrd_pkg::OP_SAMPLE, 1'b1, 16'd5);
        send_item(bhrd_pkg::OP_SAMPLE, 1'b0, 16'd7);
        send_item(bhrd_pkg::OP_SAMPLE, 1'b1, 16'd3);
        send_item(bhrd_pkg::OP_SAMPLE, 1'b0, 16'd9);
        send_item(bhrd_pkg::OP_ARM, 1'b1, 16'd1);
        set_timing(16'hFFFF, 32'd0);
        send_item(bhrd_pkg::OP_SAMPLE, 1'b1, 16'hFFFE);
        send_item(bhrd_pkg::OP_SAMPLE, 1'b1, 16'd1);
        send_item(bhrd_pkg::OP_SAMPLE, 1'b0, 16'hFFFF);
        send_item(bhrd_pkg::OP_SAMPLE, 1'b1, 16'hFFFF);
    endtask

    // Long result-side hold-off with the sender pushing back to back
    task automatic test_backpressure();
        set_timing(16'd2, 32'd40);
        gaps_enabled     = 1'b0;
        burst_left       = 0;
        hold_off_request = 60;
        send_item(bhrd_pkg::OP_ARM, 1'b1, 16'd0);
        repeat (24)
            send_item(bhrd_pkg::OP_SAMPLE, ($urandom_range(3) == 0),
                      16'($urandom_range(0, 20)));
        gaps_enabled = 1'b1;
        drain_results();
    endtask

    // Press counter runs well past 16 bits with maximum steps before it qualifies
    task automatic test_long_press();
        set_timing(16'd0, 32'd2_500_000);
        gaps_enabled = 1'b0;
        send_item(bhrd_pkg::OP_ARM, 1'b1, 16'd0);
        send_item(bhrd_pkg::OP_SAMPLE, 1'b1, 16'd1);
        repeat (40)
            send_item(bhrd_pkg::OP_SAMPLE, 1'b0, 16'hFFFF);
        send_item(bhrd_pkg::OP_SAMPLE, 1'b1, 16'd1);
        send_item(bhrd_pkg::OP_SAMPLE, 1'b1, 16'd1);
        gaps_enabled = 1'b1;
    endtask

    task automatic pick_timing();
        logic [15:0] debounce;
        logic [31:0] hold;
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 25)      debounce = 16'd0;
        else if (roll < 75) debounce = 16'($urandom_range(1, 200));
        else if (roll < 90) debounce = bhrd_pkg::DEBOUNCE_RESET;
        else                debounce = 16'($urandom_range(201, 65535));
        roll = $urandom_range(99);
        if (roll < 20)      hold = 32'd0;
        else if (roll < 80) hold = $urandom_range(1, 3000);
        else if (roll < 90) hold = bhrd_pkg::HOLD_RESET;
        else                hold = $urandom;
        elapsed_span = (hold / 6 > 65535) ? 65535 : hold / 6;
        if (elapsed_span < debounce)
            elapsed_span = debounce;
        if (elapsed_span < 8)
            elapsed_span = 8;
        set_timing(debounce, hold);
    endtask

    // Arm, settle released, bouncy press, bouncy release
    task automatic press_sequence();
        send_item(bhrd_pkg::OP_ARM, ($urandom_range(4) != 0), pick_elapsed());
        repeat ($urandom_range(2, 6))
            send_item(bhrd_pkg::OP_SAMPLE, ($urandom_range(4) != 0), pick_elapsed());
        repeat ($urandom_range(3, 12))
            send_item(bhrd_pkg::OP_SAMPLE, ($urandom_range(5) == 0), pick_elapsed());
        repeat ($urandom_range(2, 6))
            send_item(bhrd_pkg::OP_SAMPLE, ($urandom_range(5) != 0), pick_elapsed());
    endtask

    task automatic test_random_presses();
        int unsigned start_items;
        int unsigned seq_count;
        start_items = items_sent;
        while (items_sent - start_items < RANDOM_ITEMS) begin
            if (seq_count % 8 == 0)
                pick_timing();
            seq_count++;
            if ($urandom_range(99) < 15) begin
                repeat ($urandom_range(4, 16))
                    send_item(bhrd_pkg::opcode_t'($urandom_range(4) == 0), 1'($urandom),
                              16'($urandom));
            end else begin
                press_sequence();
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_timing();
        test_special_cases();
        test_backpressure();
        test_long_press();
        test_random_presses();
        drain_results();
        repeat (8) @(posedge aclk);
        $display("covered reset and extreme timings, early presses, latching, arming, stalls;");
        $display("%0d items, %0d results, %0d releases, %0d input stalls",
                 items_sent, results_checked, releases_fired, input_stalls);
        if (mismatch_count == 0 && expected_status.size() == 0) begin
            $display("tb_button_hold_release_detector OK");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatch_count,
                     expected_status.size());
            $display("tb_button_hold_release_detector NOT OK");
        end
        $finish;
    end

endmodule
